### rtl/mmcs_pkg.sv
package mmcs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LEVEL_BITS  = 8;
  localparam int NUM_W       = SAMPLE_BITS + LEVEL_BITS;
  localparam int STEP_W      = $clog2(LEVEL_BITS);

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic measure;   // update trackers from the input beat
    logic capture;   // latch the sample of a scale beat
    logic prep;      // offset, range and special-case flags
    logic mul;       // numerator = 255 * offset
    logic clamp;     // saturation check, clear quotient
    logic div_step;  // one restoring division step
    logic load_out;  // move the result into the output register
  } mmcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } mmcs_sts_t;

endpackage

### rtl/mmcs_ctrl.sv
module mmcs_ctrl
  import mmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_action,
  output logic       in_tready,
  input  mmcs_sts_t  sts,
  output mmcs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_CLAMP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_PREP;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(LEVEL_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait here while the previous result is still unread
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/mmcs_datapath.sv
module mmcs_datapath
  import mmcs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_frame_start,
  input  mmcs_cmd_t                     cmd,
  output mmcs_sts_t                     sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [LEVEL_BITS-1:0]         out_level,
  output logic                          out_flat
);

  logic signed [SAMPLE_BITS-1:0] lo_r, hi_r;
  logic                          any_seen_r;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0]        off_r;
  logic [SAMPLE_BITS-1:0]        range_r;
  logic                          flat_r, zero_r, sat_r;
  logic [NUM_W-1:0]              num_r;
  logic [NUM_W-1:0]              div_r;
  logic [LEVEL_BITS-1:0]         quot_r;

  logic                          out_valid_r;
  logic [LEVEL_BITS-1:0]         out_level_r;
  logic                          out_flat_r;

  logic signed [SAMPLE_BITS:0]   off_full;
  logic [NUM_W-1:0]              range_top;
  logic                          ge;
  logic [LEVEL_BITS-1:0]         level_nxt;

  assign off_full  = {sample_r[SAMPLE_BITS-1], sample_r} - {lo_r[SAMPLE_BITS-1], lo_r};
  assign range_top = {range_r, LEVEL_BITS'(0)};
  assign ge        = (num_r >= div_r);

  always_comb begin
    if (flat_r || zero_r) begin
      level_nxt = '0;
    end else if (sat_r) begin
      level_nxt = LEVEL_MAX;
    end else begin
      level_nxt = quot_r;
    end
  end

  // running min / max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r       <= '0;
      hi_r       <= '0;
      any_seen_r <= 1'b0;
    end else if (cmd.measure) begin
      any_seen_r <= 1'b1;
      if (in_frame_start || !any_seen_r) begin
        lo_r <= in_sample;
        hi_r <= in_sample;
      end else begin
        if (in_sample < lo_r) lo_r <= in_sample;
        if (in_sample > hi_r) hi_r <= in_sample;
      end
    end
  end

  // scale path: offset, multiply by 255, restoring divide by the range
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.prep) begin
      off_r   <= off_full[SAMPLE_BITS-1:0];
      range_r <= SAMPLE_BITS'(hi_r - lo_r);
      flat_r  <= (hi_r == lo_r);
      zero_r  <= (off_full <= 0) || (hi_r < lo_r);
    end
    if (cmd.mul) begin
      num_r <= {off_r, LEVEL_BITS'(0)} - NUM_W'(off_r);
      div_r <= NUM_W'({range_r, (LEVEL_BITS - 1)'(0)});
    end
    if (cmd.clamp) begin
      // quotient of 256 or more saturates
      sat_r  <= (num_r >= range_top);
      quot_r <= '0;
    end
    if (cmd.div_step) begin
      if (ge) num_r <= num_r - div_r;
      quot_r <= {quot_r[LEVEL_BITS-2:0], ge};
      div_r  <= div_r >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_level_r <= level_nxt;
      out_flat_r  <= flat_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_level    = out_level_r;
  assign out_flat     = out_flat_r;

endmodule

### rtl/min_max_contrast_stretch_unit.sv
// min-max contrast stretch of a frame of luma samples, streamed twice
// input beats: in_tdata carries the signed Q15.8 sample, in_tuser[0] selects
// measure (0) or scale (1), in_tuser[1] flags the first measure beat of a frame
// a measure beat updates the running min / max and gives no output beat;
// in_tready stays high after it, so measure beats can arrive back to back
// a scale beat gives one output beat: out_tdata = floor(255*(s-min)/(max-min))
// clamped to 0..255, out_tuser[0] = flat frame (max equals min, level 0)
// a scale beat occupies the unit through accept, offset/range, multiply
// by 255, saturation check, 8 restoring divide steps (one quotient bit
// per cycle) and the hand-off to the output register, in that order
// the output register lets the next beat be taken while a result waits;
// if the receiver stalls, a finished scale beat waits until the register
// frees, and in_tready stays low until then
// reset (rst_n low, synchronous) clears min, max and the seen flag to zero
// and drops out_tvalid
module min_max_contrast_stretch_unit
  import mmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample
  input  logic [1:0]  in_tuser,   // [0] action, [1] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] level
  output logic [0:0]  out_tuser   // [0] flat_frame
);

  mmcs_cmd_t cmd;
  mmcs_sts_t sts;

  logic [LEVEL_BITS-1:0] level;
  logic                  flat;

  mmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mmcs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_frame_start (in_tuser[1]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_level      (level),
    .out_flat       (flat)
  );

  assign out_tdata    = level;
  assign out_tuser[0] = flat;

  a_measure_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> in_tready)
    else $error("ready dropped after a measure beat");

  a_scale_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
    else $error("input taken while a scale beat is in progress");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result loaded but no output beat offered");

  a_flat_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("flat frame with non-zero level");

endmodule
